// ===== src/lrg_pkg.sv =====
// Package: shared types, constants and saturating arithmetic for the gradient-step block.
package lrg_pkg;

  localparam int unsigned MAX_SAMPLES = 1048576;
  localparam int unsigned LEN_W = 21;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam logic [LEN_W-1:0] EPOCH_RESET = 21'd864860;
  localparam logic [31:0] RATE_I_RESET = 32'd42949673;
  localparam logic [31:0] RATE_S_RESET = 32'd429;

  localparam logic [1:0] CFG_EPOCH_SAMPLES = 2'd0;
  localparam logic [1:0] CFG_RATE_INTERCEPT = 2'd1;
  localparam logic [1:0] CFG_RATE_SLOPE = 2'd2;

  localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] S64_MIN = {1'b1, {63{1'b0}}};
  localparam logic [47:0] S48_MAX = {1'b0, {47{1'b1}}};
  localparam logic [47:0] S48_MIN = {1'b1, {47{1'b0}}};

  typedef struct packed {
    logic signed [31:0] x_sample;
    logic signed [31:0] y_sample;
    logic last;
  } item_t;

  typedef struct packed {
    logic valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic start;
    logic [63:0] a;
    logic [63:0] b;
    logic shift32;
  } mul_req_t;

  typedef struct packed {
    logic done;
    logic sat;
    logic [63:0] value;
  } mul_rsp_t;

  typedef struct packed {
    logic start;
    logic [63:0] dividend;
    logic [LEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [63:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic sat;
    logic [63:0] value;
  } sat64_t;

  typedef struct packed {
    logic sat;
    logic [47:0] value;
  } sat48_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] es);
    logic [LEN_W-1:0] r;
    if (es == '0) begin
      r = LEN_W'(1);
    end else if (es > LEN_W'(MAX_SAMPLES)) begin
      r = LEN_W'(MAX_SAMPLES);
    end else begin
      r = es;
    end
    return r;
  endfunction

  function automatic sat64_t clamp65(input logic [64:0] s);
    sat64_t r;
    if (s[64] != s[63]) begin
      r.sat = 1'b1;
      r.value = s[64] ? S64_MIN : S64_MAX;
    end else begin
      r.sat = 1'b0;
      r.value = s[63:0];
    end
    return r;
  endfunction

  function automatic sat64_t sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    return clamp65(s);
  endfunction

  function automatic sat64_t sat_sub64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    return clamp65(s);
  endfunction

  function automatic sat48_t sat_sub48(input logic [47:0] a, input logic [63:0] b);
    logic [64:0] s;
    sat48_t r;
    s = {{17{a[47]}}, a} - {b[63], b};
    if ((&s[64:47]) || !(|s[64:47])) begin
      r.sat = 1'b0;
      r.value = s[47:0];
    end else begin
      r.sat = 1'b1;
      r.value = s[64] ? S48_MIN : S48_MAX;
    end
    return r;
  endfunction

endpackage

// ===== src/lrg_if.sv =====
// Interfaces: sample and result channels with valid/ready handshake.
interface lrg_sample_if;
  logic valid;
  logic ready;
  logic signed [31:0] x_sample;
  logic signed [31:0] y_sample;

  modport source (output valid, output x_sample, output y_sample, input ready);
  modport sink (input valid, input x_sample, input y_sample, output ready);
endinterface

interface lrg_result_if;
  logic valid;
  logic ready;
  logic signed [47:0] intercept_out;
  logic signed [47:0] slope_out;
  logic signed [63:0] mean_error;
  logic signed [63:0] mean_weighted_error;
  logic saturated;

  modport source (output valid, output intercept_out, output slope_out, output mean_error,
                  output mean_weighted_error, output saturated, input ready);
  modport sink (input valid, input intercept_out, input slope_out, input mean_error,
                input mean_weighted_error, input saturated, output ready);
endinterface

// ===== src/linear_regression_gradient_step_top.sv =====
// Top level: configuration registers, sample front end and gradient-step back end.
// Samples are taken into a four-entry queue and processed one at a time by a back end
// built around one shared 32x32 multiplier: each 64-bit product takes four partial
// products, and an ordinary sample occupies the back end for two products plus the
// prediction, error and accumulate steps. The sample that closes an epoch adds two
// divisions by the epoch length (one quotient bit a cycle) and two more products with
// their updates. The result sits in an output register, so the queue keeps filling
// while it waits.
module linear_regression_gradient_step_top
  import lrg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  lrg_sample_if.sink  samples,
  lrg_result_if.source results
);

  logic [LEN_W-1:0] epoch_samples;
  logic [31:0] rate_intercept;
  logic [31:0] rate_slope;
  logic [LEN_W-1:0] eff;
  queue_head_t head;
  logic pop;

  assign eff = eff_len(epoch_samples);

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch_samples <= EPOCH_RESET;
      rate_intercept <= RATE_I_RESET;
      rate_slope <= RATE_S_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EPOCH_SAMPLES: epoch_samples <= cfg_data[LEN_W-1:0];
        CFG_RATE_INTERCEPT: rate_intercept <= cfg_data;
        CFG_RATE_SLOPE: rate_slope <= cfg_data;
        default: epoch_samples <= epoch_samples;
      endcase
    end
  end

  lrg_front u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .eff     (eff),
    .head    (head),
    .pop     (pop)
  );

  lrg_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .pop            (pop),
    .eff            (eff),
    .rate_intercept (rate_intercept),
    .rate_slope     (rate_slope),
    .results        (results)
  );

endmodule

// ===== src/lrg_front.sv =====
// Front end: accepts samples, marks the one that ends an epoch, and queues them.
module lrg_front
  import lrg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  lrg_sample_if.sink       samples,
  input  logic [LEN_W-1:0] eff,
  output queue_head_t      head,
  input  logic             pop
);

  item_t entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr;
  logic [QUEUE_AW-1:0] rptr;
  logic [QUEUE_AW:0] count;
  logic [LEN_W-1:0] sample_counter;
  logic [LEN_W-1:0] counter_inc;
  logic push;
  logic is_last;

  assign samples.ready = (count != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign push = samples.valid && samples.ready;
  assign counter_inc = sample_counter + LEN_W'(1);
  assign is_last = (counter_inc >= eff);

  assign head.valid = (count != '0);
  assign head.item = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= '{x_sample: samples.x_sample, y_sample: samples.y_sample,
                         last: is_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
      sample_counter <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QUEUE_AW'(1);
        sample_counter <= is_last ? '0 : counter_inc;
      end
      if (pop) begin
        rptr <= rptr + QUEUE_AW'(1);
      end
      case ({push, pop})
        2'b10: count <= count + (QUEUE_AW+1)'(1);
        2'b01: count <= count - (QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/lrg_mul.sv =====
// Multiplier: signed 64x64 product over four 32x32 partial products, floor shift, saturation.
module lrg_mul
  import lrg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  typedef enum logic [3:0] {
    M_IDLE  = 4'b0001,
    M_RUN   = 4'b0010,
    M_SIGN  = 4'b0100,
    M_SHIFT = 4'b1000
  } mul_state_t;

  mul_state_t state;
  logic [63:0] ua;
  logic [63:0] ub;
  logic neg;
  logic shift32;
  logic [2:0] cnt;
  logic [63:0] prod;
  logic [1:0] pos;
  logic [127:0] acc;
  logic [31:0] a_part;
  logic [31:0] b_part;
  logic [127:0] prod_aligned;
  logic fits;
  logic [63:0] shifted;

  assign a_part = cnt[1] ? ua[63:32] : ua[31:0];
  assign b_part = cnt[0] ? ub[63:32] : ub[31:0];
  assign prod_aligned = {64'b0, prod} << {pos, 5'b0};

  always_comb begin
    if (shift32) begin
      fits = (&acc[127:95]) || !(|acc[127:95]);
      shifted = acc[95:32];
    end else begin
      fits = (&acc[127:79]) || !(|acc[127:79]);
      shifted = acc[79:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (req.start) begin
            state <= M_RUN;
          end
        end
        M_RUN: begin
          if (cnt == 3'd4) begin
            state <= M_SIGN;
          end
        end
        M_SIGN: state <= M_SHIFT;
        M_SHIFT: begin
          rsp.done <= 1'b1;
          rsp.sat <= !fits;
          rsp.value <= fits ? shifted : (acc[127] ? S64_MIN : S64_MAX);
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      M_IDLE: begin
        ua <= req.a[63] ? (64'd0 - req.a) : req.a;
        ub <= req.b[63] ? (64'd0 - req.b) : req.b;
        neg <= req.a[63] ^ req.b[63];
        shift32 <= req.shift32;
        cnt <= '0;
        acc <= '0;
      end
      M_RUN: begin
        if (cnt != 3'd4) begin
          prod <= a_part * b_part;
          pos <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
        end
        if (cnt != 3'd0) begin
          acc <= acc + prod_aligned;
        end
        cnt <= cnt + 3'd1;
      end
      M_SIGN: begin
        if (neg) begin
          acc <= 128'd0 - acc;
        end
      end
      default: cnt <= '0;
    endcase
  end

endmodule

// ===== src/lrg_div.sv =====
// Divider: signed 64-bit by positive epoch length, one quotient bit a cycle, truncating.
module lrg_div
  import lrg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_FIN  = 3'b100
  } div_state_t;

  div_state_t state;
  logic [63:0] mag;
  logic [LEN_W:0] rem;
  logic [LEN_W:0] rem_shift;
  logic [LEN_W:0] divisor;
  logic [5:0] cnt;
  logic neg;
  logic take;

  assign rem_shift = {rem[LEN_W-1:0], mag[63]};
  assign take = (rem_shift >= divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (req.start) begin
            state <= D_RUN;
          end
        end
        D_RUN: begin
          if (cnt == 6'd0) begin
            state <= D_FIN;
          end
        end
        D_FIN: begin
          rsp.done <= 1'b1;
          rsp.quotient <= neg ? (64'd0 - mag) : mag;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      D_IDLE: begin
        mag <= req.dividend[63] ? (64'd0 - req.dividend) : req.dividend;
        neg <= req.dividend[63];
        divisor <= {1'b0, req.divisor};
        rem <= '0;
        cnt <= 6'd63;
      end
      D_RUN: begin
        rem <= take ? (rem_shift - divisor) : rem_shift;
        mag <= {mag[62:0], take};
        cnt <= cnt - 6'd1;
      end
      default: cnt <= '0;
    endcase
  end

endmodule

// ===== src/lrg_back.sv =====
// Back end: per-sample error accumulation and end-of-epoch coefficient update.
module lrg_back
  import lrg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  queue_head_t      head,
  output logic             pop,
  input  logic [LEN_W-1:0] eff,
  input  logic [31:0]      rate_intercept,
  input  logic [31:0]      rate_slope,
  lrg_result_if.source     results
);

  typedef enum logic [13:0] {
    B_IDLE   = 14'h0001,
    B_MUL_PX = 14'h0002,
    B_PRED   = 14'h0004,
    B_ERR    = 14'h0008,
    B_ACC    = 14'h0010,
    B_MUL_EX = 14'h0020,
    B_WACC   = 14'h0040,
    B_DIV_E  = 14'h0080,
    B_DIV_W  = 14'h0100,
    B_MUL_I  = 14'h0200,
    B_UPD_I  = 14'h0400,
    B_MUL_S  = 14'h0800,
    B_UPD_S  = 14'h1000,
    B_EMIT   = 14'h2000
  } back_state_t;

  back_state_t state;
  mul_req_t mreq;
  mul_rsp_t mrsp;
  div_req_t dreq;
  div_rsp_t drsp;

  logic [47:0] intercept;
  logic [47:0] slope;
  logic [63:0] error_sum;
  logic [63:0] weighted_error_sum;
  logic saturation_seen;
  logic [31:0] x_reg;
  logic [31:0] y_reg;
  logic last_reg;
  logic [63:0] m_reg;
  logic [63:0] pe;
  logic [63:0] mean0;
  logic [63:0] mean1;

  logic out_valid;
  logic [47:0] out_intercept;
  logic [47:0] out_slope;
  logic [63:0] out_mean0;
  logic [63:0] out_mean1;
  logic out_sat;

  sat64_t pred_r;
  sat64_t err_r;
  sat64_t acc_r;
  sat64_t wacc_r;
  sat48_t upd_r;
  logic emit_go;

  assign pop = (state == B_IDLE) && head.valid;
  assign emit_go = (state == B_EMIT) && (!out_valid || results.ready);

  assign pred_r = sat_add64({{16{intercept[47]}}, intercept}, m_reg);
  assign err_r = sat_sub64(pe, {{16{y_reg[31]}}, y_reg, 16'b0});
  assign acc_r = sat_add64(error_sum, pe);
  assign wacc_r = sat_add64(weighted_error_sum, m_reg);
  assign upd_r = sat_sub48((state == B_UPD_I) ? intercept : slope, m_reg);

  always_comb begin
    mreq = '{start: 1'b0, a: '0, b: '0, shift32: 1'b0};
    dreq = '{start: 1'b0, dividend: '0, divisor: eff};
    case (state)
      B_IDLE: begin
        mreq.start = head.valid;
        mreq.a = {{16{slope[47]}}, slope};
        mreq.b = {{32{head.item.x_sample[31]}}, head.item.x_sample};
      end
      B_ACC: begin
        mreq.start = 1'b1;
        mreq.a = pe;
        mreq.b = {{32{x_reg[31]}}, x_reg};
      end
      B_WACC: begin
        dreq.start = last_reg;
        dreq.dividend = error_sum;
      end
      B_DIV_E: begin
        dreq.start = drsp.done;
        dreq.dividend = weighted_error_sum;
      end
      B_DIV_W: begin
        mreq.start = drsp.done;
        mreq.a = {32'b0, rate_intercept};
        mreq.b = mean0;
        mreq.shift32 = 1'b1;
      end
      B_UPD_I: begin
        mreq.start = 1'b1;
        mreq.a = {32'b0, rate_slope};
        mreq.b = mean1;
        mreq.shift32 = 1'b1;
      end
      default: mreq.start = 1'b0;
    endcase
  end

  lrg_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  lrg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      intercept <= '0;
      slope <= '0;
      error_sum <= '0;
      weighted_error_sum <= '0;
      saturation_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (head.valid) begin
            state <= B_MUL_PX;
          end
        end
        B_MUL_PX: begin
          if (mrsp.done) begin
            saturation_seen <= saturation_seen | mrsp.sat;
            state <= B_PRED;
          end
        end
        B_PRED: begin
          saturation_seen <= saturation_seen | pred_r.sat;
          state <= B_ERR;
        end
        B_ERR: begin
          saturation_seen <= saturation_seen | err_r.sat;
          state <= B_ACC;
        end
        B_ACC: begin
          error_sum <= acc_r.value;
          saturation_seen <= saturation_seen | acc_r.sat;
          state <= B_MUL_EX;
        end
        B_MUL_EX: begin
          if (mrsp.done) begin
            saturation_seen <= saturation_seen | mrsp.sat;
            state <= B_WACC;
          end
        end
        B_WACC: begin
          weighted_error_sum <= wacc_r.value;
          saturation_seen <= saturation_seen | wacc_r.sat;
          state <= last_reg ? B_DIV_E : B_IDLE;
        end
        B_DIV_E: begin
          if (drsp.done) begin
            state <= B_DIV_W;
          end
        end
        B_DIV_W: begin
          if (drsp.done) begin
            state <= B_MUL_I;
          end
        end
        B_MUL_I: begin
          if (mrsp.done) begin
            saturation_seen <= saturation_seen | mrsp.sat;
            state <= B_UPD_I;
          end
        end
        B_UPD_I: begin
          intercept <= upd_r.value;
          saturation_seen <= saturation_seen | upd_r.sat;
          state <= B_MUL_S;
        end
        B_MUL_S: begin
          if (mrsp.done) begin
            saturation_seen <= saturation_seen | mrsp.sat;
            state <= B_UPD_S;
          end
        end
        B_UPD_S: begin
          slope <= upd_r.value;
          saturation_seen <= saturation_seen | upd_r.sat;
          state <= B_EMIT;
        end
        B_EMIT: begin
          if (emit_go) begin
            error_sum <= '0;
            weighted_error_sum <= '0;
            saturation_seen <= 1'b0;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x_reg <= head.item.x_sample;
      y_reg <= head.item.y_sample;
      last_reg <= head.item.last;
    end
    if (mrsp.done) begin
      m_reg <= mrsp.value;
    end
    if (state == B_PRED) begin
      pe <= pred_r.value;
    end
    if (state == B_ERR) begin
      pe <= err_r.value;
    end
    if ((state == B_DIV_E) && drsp.done) begin
      mean0 <= drsp.quotient;
    end
    if ((state == B_DIV_W) && drsp.done) begin
      mean1 <= drsp.quotient;
    end
    if (emit_go) begin
      out_intercept <= intercept;
      out_slope <= slope;
      out_mean0 <= mean0;
      out_mean1 <= mean1;
      out_sat <= saturation_seen;
    end
  end

  assign results.valid = out_valid;
  assign results.intercept_out = out_intercept;
  assign results.slope_out = out_slope;
  assign results.mean_error = out_mean0;
  assign results.mean_weighted_error = out_mean1;
  assign results.saturated = out_sat;

endmodule
